### src/trial_division_prime_test_core_assert.svh
// assertion macros shared by the prime test rtl
`ifndef TRIAL_DIVISION_PRIME_TEST_CORE_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_CORE_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define TDPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/tdpt_pkg.sv
// shared constants and types for the trial division prime test
package tdpt_pkg;

  // width of the candidate field on the input channel
  localparam int CANDIDATE_WIDTH = 32;

  // default width of the number that is actually tested
  localparam int DEFAULT_NUMBER_WIDTH = 32;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### src/tdpt_cand_if.sv
// valid/ready channel carrying one candidate per beat
interface tdpt_cand_if;
  logic                                 valid;
  logic                                 ready;
  logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink (input valid, input candidate, output ready);
endinterface

### src/tdpt_res_if.sv
// valid/ready channel carrying one prime flag per beat
interface tdpt_res_if;
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink (input valid, input is_prime, output ready);
endinterface

### src/tdpt_div.sv
// restoring divider, one quotient bit per cycle, shared by all trial divisors
module tdpt_div #(
  parameter int NUMBER_WIDTH = tdpt_pkg::DEFAULT_NUMBER_WIDTH
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [NUMBER_WIDTH-1:0]   dividend,
  input  logic [NUMBER_WIDTH-1:0]   divisor,
  output logic [NUMBER_WIDTH-1:0]   quotient,
  output logic [NUMBER_WIDTH-1:0]   remainder,
  output tdpt_pkg::div_status_t     status
);

  localparam int CW = $clog2(NUMBER_WIDTH + 1);

  logic [NUMBER_WIDTH-1:0] quo;
  logic [NUMBER_WIDTH-1:0] rem;
  logic [NUMBER_WIDTH-1:0] dvs;
  logic [CW-1:0]           cnt;
  logic                    busy;
  logic                    done;

  logic [NUMBER_WIDTH:0]   trial;
  logic                    fits;

  // shift the next dividend bit into the partial remainder and compare
  always_comb begin
    trial = {rem, quo[NUMBER_WIDTH-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  // iteration control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= CW'(NUMBER_WIDTH);
        busy <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= NUMBER_WIDTH'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[NUMBER_WIDTH-1:0];
        end
        quo <= {quo[NUMBER_WIDTH-2:0], fits};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient    = quo;
  assign remainder   = rem;
  assign status.busy = busy;
  assign status.done = done;

endmodule

### src/trial_division_prime_test_core.sv
// Trial division prime test: one candidate in, one prime flag out.
// Channels: cand (sink) carries a 32-bit candidate, res (source) carries
// is_prime. A beat moves when valid and ready are both high.
// Only the low NUMBER_WIDTH bits of the candidate are tested.
// Values below 2, 2 itself and even values are decided in the accept cycle
// and the flag is loaded into the output register from S_FINISH once it is free.
// Odd values from 3 upward try odd divisors 3, 5, 7, ... on one shared
// restoring divider that produces one quotient bit per cycle, and each
// divisor runs through S_START and S_WAIT. A test stops when the quotient
// drops below the divisor (prime) or a remainder is zero (not prime).
// cand.ready is high only while no test is in progress; one item at a time.
// The result sits in an output register; a new candidate may be accepted
// while it waits, and a finished answer waits until that register is free.
// Reset (rst, synchronous) drops any test in progress and any pending result.
module trial_division_prime_test_core #(
  parameter int NUMBER_WIDTH = tdpt_pkg::DEFAULT_NUMBER_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  tdpt_cand_if.sink    cand,
  tdpt_res_if.source   res
);

  `include "trial_division_prime_test_core_assert.svh"

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_FINISH
  } state_t;

  state_t                  state;
  logic [NUMBER_WIDTH-1:0] num;
  logic [NUMBER_WIDTH-1:0] dvs;
  logic                    ans;
  logic                    res_valid;
  logic                    prime_flag;

  logic [NUMBER_WIDTH-1:0] n_in;
  logic                    in_beat;
  logic                    div_start;
  logic [NUMBER_WIDTH-1:0] div_quo;
  logic [NUMBER_WIDTH-1:0] div_rem;
  tdpt_pkg::div_status_t   div_stat;
  logic                    slot_free;
  logic                    res_load;

  // candidate trimmed or zero-extended to the tested width
  assign n_in      = NUMBER_WIDTH'(cand.candidate);
  assign cand.ready = (state == S_IDLE);
  assign in_beat   = cand.valid && cand.ready;
  assign div_start = (state == S_START);
  assign slot_free = !res_valid || res.ready;
  assign res_load  = (state == S_FINISH) && slot_free;

  // shared divider
  tdpt_div #(
    .NUMBER_WIDTH (NUMBER_WIDTH)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (num),
    .divisor   (dvs),
    .quotient  (div_quo),
    .remainder (div_rem),
    .status    (div_stat)
  );

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      // load a finished answer or drop a beat that was taken
      if (res_load) begin
        res_valid  <= 1'b1;
        prime_flag <= ans;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_beat) begin
            num <= n_in;
            dvs <= NUMBER_WIDTH'(3);
            if (n_in < NUMBER_WIDTH'(2)) begin
              ans   <= 1'b0;
              state <= S_FINISH;
            end else if (n_in == NUMBER_WIDTH'(2)) begin
              ans   <= 1'b1;
              state <= S_FINISH;
            end else if (!n_in[0]) begin
              ans   <= 1'b0;
              state <= S_FINISH;
            end else begin
              state <= S_START;
            end
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (div_stat.done) begin
            if (div_quo < dvs) begin
              // divisor passed the square root
              ans   <= 1'b1;
              state <= S_FINISH;
            end else if (div_rem == '0) begin
              ans   <= 1'b0;
              state <= S_FINISH;
            end else begin
              dvs   <= dvs + NUMBER_WIDTH'(2);
              state <= S_START;
            end
          end
        end
        S_FINISH: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid    = res_valid;
  assign res.is_prime = prime_flag;

  // checks
  `TDPT_ASSERT_NOW(a_start_idle, div_start, !div_stat.busy, "divider started while busy")
  `TDPT_ASSERT_NOW(a_odd_divisor, state == S_WAIT, dvs[0], "trial divisor is even")
  `TDPT_ASSERT_NOW(a_done_in_wait, div_stat.done, state == S_WAIT, "divider done outside wait")
  `TDPT_ASSERT_NEXT(a_even_fast, in_beat && !n_in[0], state == S_FINISH, "even not decided")

endmodule

### sim/tb.sv
// self-checking testbench for the trial division prime test core
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW           = tdpt_pkg::CANDIDATE_WIDTH;
  localparam int NUM_W        = tdpt_pkg::DEFAULT_NUMBER_WIDTH;
  localparam int RANDOM_ITEMS = 64;
  localparam int FILL_ITEMS   = 12;
  localparam int QUIET_ITEMS  = 20;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int NUM_PROBES   = 24;

  // one directed row: candidate, whether the flag is typed in, and that flag
  typedef struct packed {
    logic [CW-1:0] value;
    logic          known;
    logic          flag;
  } probe_t;

  // one outstanding answer
  typedef struct packed {
    logic [CW-1:0] value;
    logic          flag;
  } verdict_t;

  localparam probe_t PROBES [NUM_PROBES] = '{
    '{32'd0,          1'b1, 1'b0},  // below two
    '{32'd1,          1'b1, 1'b0},
    '{32'd2,          1'b1, 1'b1},  // the only even prime
    '{32'd3,          1'b1, 1'b1},  // odd, quotient already below the first divisor
    '{32'd4,          1'b1, 1'b0},
    '{32'hFFFFFFFF,   1'b1, 1'b0},  // all ones, multiple of three
    '{32'hFFFFFFFE,   1'b1, 1'b0},
    '{32'h80000000,   1'b1, 1'b0},
    '{32'd5,          1'b0, 1'b0},
    '{32'd6,          1'b1, 1'b0},
    '{32'd9,          1'b1, 1'b0},  // squares hit the divisor bound exactly
    '{32'd25,         1'b1, 1'b0},
    '{32'd49,         1'b1, 1'b0},
    '{32'd121,        1'b0, 1'b0},
    '{32'd63001,      1'b0, 1'b0},
    '{32'd65521,      1'b0, 1'b0},
    '{32'd65535,      1'b0, 1'b0},
    '{32'd1000003,    1'b0, 1'b0},
    '{32'h7FFFFFFD,   1'b0, 1'b0},
    '{32'h55555555,   1'b0, 1'b0},
    '{32'hAAAAAAAB,   1'b0, 1'b0},
    '{32'h80000001,   1'b0, 1'b0},
    '{32'd196611,     1'b0, 1'b0},
    '{32'd7,          1'b1, 1'b1}
  };

  logic clk;
  logic rst;

  tdpt_cand_if cand_ch ();
  tdpt_res_if  res_ch ();

  trial_division_prime_test_core #(
    .NUMBER_WIDTH(NUM_W)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .cand(cand_ch),
    .res (res_ch)
  );

  verdict_t pending_flags[$];
  int       error_count = 0;
  bit       quiet       = 1'b0;
  bit       fill_req    = 1'b0;
  int       hold_left   = 0;

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // trial division on the low NUM_W bits of the candidate
  function automatic bit is_prime_number(logic [CW-1:0] raw);
    int              w;
    longint unsigned n;
    longint unsigned d;
    w = (NUM_W < 1) ? 1 : ((NUM_W > 64) ? 64 : NUM_W);
    n = 64'(raw) & (~64'd0 >> (64 - w));
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if ((n & 64'd1) == 0) return 1'b0;
    for (d = 3; d <= n / d; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // drive one candidate beat, optionally after an idle burst
  task automatic offer(input logic [CW-1:0] value, input bit known, input bit flag,
                       input bit may_idle);
    verdict_t v;
    int       gap;
    if (may_idle && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      cand_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cand_ch.valid     <= 1'b1;
    cand_ch.candidate <= value;
    @(posedge clk);
    while (!cand_ch.ready) @(posedge clk);
    v.value = value;
    v.flag  = known ? flag : is_prime_number(value);
    pending_flags.push_back(v);
  endtask

  // result side: random back-pressure plus one long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left--;
      end else if (fill_req) begin
        fill_req = 1'b0;
        hold_left = LONG_HOLD - 1;
        res_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        hold_left = $urandom_range(1, 17) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // compare every result beat with the oldest outstanding answer
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_flags.size() == 0) begin
        $display("%0t: unexpected is_prime beat, expected none, got %0b", $time,
                 res_ch.is_prime);
        error_count++;
      end else begin
        v = pending_flags.pop_front();
        if (res_ch.is_prime !== v.flag) begin
          $display("%0t: is_prime for candidate %0d, expected %0b, got %0b", $time,
                   v.value, v.flag, res_ch.is_prime);
          error_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [CW-1:0] value;
    logic [CW-1:0] p;
    logic [CW-1:0] k;
    int            kind;
    cand_ch.valid     = 1'b0;
    cand_ch.candidate = '0;
    rst               = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed rows
    for (int i = 0; i < NUM_PROBES; i++) begin
      offer(PROBES[i].value, PROBES[i].known, PROBES[i].flag, 1'b1);
    end
    @(negedge clk);
    cand_ch.valid <= 1'b0;

    // pause until every answer is back
    while (pending_flags.size() != 0) @(negedge clk);

    // back-to-back quick items against a long result hold-off
    fill_req = 1'b1;
    for (int i = 0; i < FILL_ITEMS; i++) begin
      offer($urandom() & ~32'd1, 1'b0, 1'b0, 1'b0);
    end

    // random items, no idling in the last stretch
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        value = $urandom_range(0, 65535);
      end else if (kind < 60) begin
        value = $urandom_range(0, 300);
      end else if (kind < 75) begin
        value = $urandom() & ~32'd1;
      end else if (kind < 95) begin
        // wide multiple of a small odd factor keeps the test short
        p     = 2 * $urandom_range(1, 30) + 1;
        k     = $urandom_range(1, 32'hFFFFFFFF / p);
        value = p * k;
      end else begin
        p     = $urandom_range(1, 127) * 2 + 1;
        value = p * p;
      end
      offer(value, 1'b0, 1'b0, 1'b1);
    end
    @(negedge clk);
    cand_ch.valid <= 1'b0;

    // drain, then watch for stray beats
    while (pending_flags.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_flags.size() == 0) begin
      $display("trial_division_prime_test_core: match");
    end else begin
      $display("trial_division_prime_test_core: mismatch");
    end
    $finish;
  end

  // watchdog
  initial begin
    #30_000_000;
    $display("trial_division_prime_test_core: mismatch");
    $finish;
  end

endmodule

### trial_division_prime_test_core.f
+incdir+src
src/tdpt_pkg.sv
src/tdpt_cand_if.sv
src/tdpt_res_if.sv
src/tdpt_div.sv
src/trial_division_prime_test_core.sv
sim/tb.sv
